[hw/rtl/lmss_pkg.sv]
package lmss_pkg;

  // The daisy-chained shift register is always eight bits long.
  localparam int unsigned ChainW = 8;

  localparam logic [ChainW-1:0] ChainMsb  = 8'b10000000;
  localparam logic [ChainW-1:0] ChainLsb  = 8'b00000001;
  localparam logic [ChainW-1:0] ChainOnes = 8'hFF;

  // Input item codes.
  localparam logic ActTick  = 1'b0;
  localparam logic ActWrite = 1'b1;

  // Configuration register indexes.
  localparam logic CfgPlaneAColor = 1'b0;
  localparam logic CfgPlaneBColor = 1'b1;

  // Color code bits.
  localparam int unsigned ColorRed   = 0;
  localparam int unsigned ColorGreen = 1;
  localparam int unsigned ColorBlue  = 2;

  // Scan sequencer state.
  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StBlank = 3'b010,
    StLight = 3'b100
  } state_e;

  // Patterns loaded into the chain, one per serial line.
  typedef struct packed {
    logic [ChainW-1:0] rows;
    logic [ChainW-1:0] reds;
    logic [ChainW-1:0] grns;
    logic [ChainW-1:0] blus;
  } pattern_t;

  // Control from the sequencer to the serializer.
  typedef struct packed {
    logic load;
    logic shift;
  } shift_ctrl_t;

  // Current serial bits at the head of the chain.
  typedef struct packed {
    logic row;
    logic red;
    logic green;
    logic blue;
  } lines_t;

endpackage

[hw/rtl/lmss_fb.sv]
module lmss_fb import lmss_pkg::*; #(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [$clog2(ROWS)-1:0] wr_row_i,
  input  logic [$clog2(COLS)-1:0] wr_col_i,
  input  logic                    wr_a_i,
  input  logic                    wr_b_i,
  input  logic [$clog2(ROWS)-1:0] rd_row_i,
  input  logic [$clog2(COLS)-1:0] rd_col_i,
  output logic                    lit_a_o,
  output logic                    lit_b_o
);

  logic [COLS-1:0] plane_a_q [ROWS];
  logic [COLS-1:0] plane_b_q [ROWS];

  // Cell writes; both planes are cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        plane_a_q[r] <= '0;
        plane_b_q[r] <= '0;
      end
    end else if (wr_en_i) begin
      plane_a_q[wr_row_i][wr_col_i] <= wr_a_i;
      plane_b_q[wr_row_i][wr_col_i] <= wr_b_i;
    end
  end

  // Read of the scanned cell.
  assign lit_a_o = plane_a_q[rd_row_i][rd_col_i];
  assign lit_b_o = plane_b_q[rd_row_i][rd_col_i];

endmodule

[hw/rtl/lmss_shift.sv]
module lmss_shift import lmss_pkg::*; (
  input  logic        clk_i,
  input  shift_ctrl_t ctrl_i,
  input  pattern_t    pat_i,
  output lines_t      lines_o
);

  pattern_t chain_q, chain_d;

  // Load a new set of patterns or move every line one bit toward the MSB.
  always_comb begin
    chain_d = chain_q;
    if (ctrl_i.load) begin
      chain_d = pat_i;
    end else if (ctrl_i.shift) begin
      chain_d.rows = {chain_q.rows[ChainW-2:0], 1'b1};
      chain_d.reds = {chain_q.reds[ChainW-2:0], 1'b1};
      chain_d.grns = {chain_q.grns[ChainW-2:0], 1'b1};
      chain_d.blus = {chain_q.blus[ChainW-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    chain_q <= chain_d;
  end

  // The MSB of each line is the bit on the wire.
  assign lines_o.row   = chain_q.rows[ChainW-1];
  assign lines_o.red   = chain_q.reds[ChainW-1];
  assign lines_o.green = chain_q.grns[ChainW-1];
  assign lines_o.blue  = chain_q.blus[ChainW-1];

endmodule

[hw/rtl/rgb_led_matrix_scan_shifter_core.sv]
// Scan driver for an RGB LED matrix behind an eight-bit daisy-chained shift
// register. Input items arrive on in_valid_i/in_stall_o. A write item
// (action_i high) sets one cell of both framebuffer planes and
// produces nothing; cells outside ROWS x COLS are ignored. A scan tick moves
// the scan position column first, then row, and emits eight blanking shifts
// with all lines high, followed by eight lighting shifts MSB first when the
// cell is lit in plane A or B. last_o marks the final shift of the tick.
// Each shift is one item on out_valid_o/out_stall_i. The first shift is
// valid the cycle after the tick is accepted and one shift leaves per
// unstalled cycle. in_stall_o is high while a tick is being shifted out.
// A stall on the output holds the current shift and its fields unchanged.
// Configuration writes (cfg_valid_i, always ready) set the plane colors.
// Reset clears both planes, sets the colors to red for plane A and blue
// for plane B, and parks the scan position so that the first tick shows
// cell (0,0).
module rgb_led_matrix_scan_shifter_core import lmss_pkg::*; #(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [2:0] cfg_data_i,
  // Input items
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [2:0] cell_row_i,
  input  logic [2:0] cell_col_i,
  input  logic       plane_a_bit_i,
  input  logic       plane_b_bit_i,
  // Result items
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       row_line_o,
  output logic       red_line_o,
  output logic       green_line_o,
  output logic       blue_line_o,
  output logic       last_o
);

  localparam int unsigned RowW = $clog2(ROWS);
  localparam int unsigned ColW = $clog2(COLS);
  localparam logic [RowW-1:0] RowLast = RowW'(ROWS - 1);
  localparam logic [ColW-1:0] ColLast = ColW'(COLS - 1);
  localparam logic [3:0] RowsLim = 4'(ROWS);
  localparam logic [3:0] ColsLim = 4'(COLS);

  state_e          state_q, state_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            lit_q, lit_d;
  logic [2:0]      color_a_q, color_b_q;
  logic [RowW-1:0] scan_row_q, scan_row_d;
  logic [ColW-1:0] scan_col_q, scan_col_d;

  logic        in_acc, tick_acc, wr_acc, wr_in_range, out_acc;
  logic        lit_a, lit_b;
  logic [2:0]  color;
  logic [ChainW-1:0] col_mask;
  pattern_t    pat;
  shift_ctrl_t ctrl;
  lines_t      lines;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign tick_acc    = in_acc && (action_i == ActTick);
  assign wr_in_range = ({1'b0, cell_row_i} < RowsLim) && ({1'b0, cell_col_i} < ColsLim);
  assign wr_acc      = in_acc && (action_i == ActWrite) && wr_in_range;
  assign out_valid_o = (state_q != StIdle);
  assign out_acc     = out_valid_o && !out_stall_i;

  // Color registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_a_q <= 3'd1;
      color_b_q <= 3'd4;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgPlaneAColor: color_a_q <= cfg_data_i;
        CfgPlaneBColor: color_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next scan position: column first, then row, each with wrap.
  always_comb begin
    scan_row_d = scan_row_q;
    scan_col_d = scan_col_q;
    if (scan_col_q == ColLast) begin
      scan_col_d = '0;
      scan_row_d = (scan_row_q == RowLast) ? '0 : scan_row_q + 1'b1;
    end else begin
      scan_col_d = scan_col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q <= RowLast;
      scan_col_q <= ColLast;
    end else if (tick_acc) begin
      scan_row_q <= scan_row_d;
      scan_col_q <= scan_col_d;
    end
  end

  lmss_fb #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_fb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_acc),
    .wr_row_i (cell_row_i[RowW-1:0]),
    .wr_col_i (cell_col_i[ColW-1:0]),
    .wr_a_i   (plane_a_bit_i),
    .wr_b_i   (plane_b_bit_i),
    .rd_row_i (scan_row_d),
    .rd_col_i (scan_col_d),
    .lit_a_o  (lit_a),
    .lit_b_o  (lit_b)
  );

  // Patterns for the lighting shifts of the newly scanned cell.
  always_comb begin
    color    = lit_a ? color_a_q : color_b_q;
    col_mask = ~(ChainLsb << scan_col_d);
    pat.rows = ~(ChainLsb << scan_row_d);
    pat.reds = color[ColorRed]   ? col_mask : ChainOnes;
    pat.grns = color[ColorGreen] ? col_mask : ChainOnes;
    pat.blus = color[ColorBlue]  ? col_mask : ChainOnes;
  end

  assign ctrl.load  = tick_acc;
  assign ctrl.shift = out_acc && (state_q == StLight);

  lmss_shift u_shift (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .pat_i   (pat),
    .lines_o (lines)
  );

  // Sequencer: blanking phase, then the optional lighting phase.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    lit_d   = lit_q;
    case (state_q)
      StIdle: begin
        if (tick_acc) begin
          state_d = StBlank;
          cnt_d   = '0;
          lit_d   = lit_a || lit_b;
        end
      end
      StBlank: begin
        if (out_acc) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == 3'd7) begin
            state_d = lit_q ? StLight : StIdle;
          end
        end
      end
      StLight: begin
        if (out_acc) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == 3'd7) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      lit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lit_q   <= lit_d;
    end
  end

  // Blanking shifts drive every line high.
  assign row_line_o   = (state_q == StLight) ? lines.row   : 1'b1;
  assign red_line_o   = (state_q == StLight) ? lines.red   : 1'b1;
  assign green_line_o = (state_q == StLight) ? lines.green : 1'b1;
  assign blue_line_o  = (state_q == StLight) ? lines.blue  : 1'b1;
  assign last_o       = (cnt_q == 3'd7) &&
                        ((state_q == StLight) || ((state_q == StBlank) && !lit_q));

endmodule
